// File: hdl/spjq_pkg.sv
// Shared types, constants and codes of the sorted priority job queue.
`default_nettype none
package spjq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
	} job_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic remove;
		job_t job;
	} cell_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] removed_id;
		logic [7:0]  removed_priority;
		logic [3:0]  job_count;
		logic [15:0] head_id;
		logic [7:0]  head_priority;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/spjq_if.sv
// Valid/ready channel interfaces for job requests and job results.
`default_nettype none
interface spjq_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] job_id;
	logic [7:0]  job_priority;

	modport source (output valid, output operation, output job_id, output job_priority,
		input ready);
	modport sink (input valid, input operation, input job_id, input job_priority,
		output ready);
endinterface

interface spjq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] removed_id;
	logic [7:0]  removed_priority;
	logic [3:0]  job_count;
	logic [15:0] head_id;
	logic [7:0]  head_priority;

	modport source (output valid, output status, output removed_id, output removed_priority,
		output job_count, output head_id, output head_priority, input ready);
	modport sink (input valid, input status, input removed_id, input removed_priority,
		input job_count, input head_id, input head_priority, output ready);
endinterface
`default_nettype wire

// File: hdl/spjq_cell.sv
// One slot of the sorted chain: holds a job and shifts it left or right.
`default_nettype none
module spjq_cell (
	input  wire                   clk,
	input  wire                   occupied,
	input  spjq_pkg::cell_cmd_t   cmd,
	input  spjq_pkg::job_t        left_job,
	input  wire                   left_stay,
	input  spjq_pkg::job_t        right_job,
	output spjq_pkg::job_t        job_q,
	output logic                  stay
);
	import spjq_pkg::*;

	// A held job stays put on insert when its priority is not larger than the new one.
	assign stay = occupied && (job_q.prio <= cmd.job.prio);

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!stay) begin
				// The first cell that does not stay takes the new job; the rest shift right.
				job_q <= left_stay ? cmd.job : left_job;
			end
		end else if (cmd.remove) begin
			job_q <= right_job;
		end
	end

endmodule
`default_nettype wire

// File: hdl/sorted_priority_job_queue.sv
// Sorted priority job queue: a chain of compare-and-shift cells with a result register.
// A result is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle unless the result side stalls; every cell compares
// and shifts in the same cycle. A request is taken whenever the result register is
// empty or being drained. Reset (arst_n low) empties the queue and the result
// register; slot contents are not cleared, since only occupied slots are ever read.
`default_nettype none
module sorted_priority_job_queue (
	input wire        clk,
	input wire        arst_n,
	spjq_req_if.sink  req,
	spjq_rsp_if.source rsp
);
	import spjq_pkg::*;

	// Occupancy count; cell i holds a job when i is below it.
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	logic             accept;
	cell_cmd_t        cmd;

	job_t job_q [QUEUE_DEPTH];
	logic stay  [QUEUE_DEPTH];
	logic occ   [QUEUE_DEPTH];

	result_t          res;
	result_t          res_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] next_count;
	logic [CNT_W+3:0] cnt_ext;
	logic             sorted_ok;

	// The result register decouples the two sides: a new request is taken while
	// the previous result is being accepted downstream.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.insert   = accept && (req.operation == OP_INSERT) && !full;
		cmd.remove   = accept && (req.operation == OP_REMOVE) && !empty;
		cmd.job.id   = req.job_id;
		cmd.job.prio = req.job_priority;
	end

	// The chain of cells. Cell zero sees a neighbor that always stays, so it takes
	// the new job unless its own job stays. The last cell refills from itself on
	// a remove; that slot then falls outside the count.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			spjq_cell u_cell (
				.clk      (clk),
				.occupied (occ[i]),
				.cmd      (cmd),
				.left_job (cmd.job),
				.left_stay(1'b1),
				.right_job(job_q[i+1]),
				.job_q    (job_q[i]),
				.stay     (stay[i])
			);
		end else if (i == QUEUE_DEPTH - 1) begin : g_last
			spjq_cell u_cell (
				.clk      (clk),
				.occupied (occ[i]),
				.cmd      (cmd),
				.left_job (job_q[i-1]),
				.left_stay(stay[i-1]),
				.right_job(job_q[i]),
				.job_q    (job_q[i]),
				.stay     (stay[i])
			);
		end else begin : g_mid
			spjq_cell u_cell (
				.clk      (clk),
				.occupied (occ[i]),
				.cmd      (cmd),
				.left_job (job_q[i-1]),
				.left_stay(stay[i-1]),
				.right_job(job_q[i+1]),
				.job_q    (job_q[i]),
				.stay     (stay[i])
			);
		end
	end

	always_comb begin
		next_count = count_q;
		if (cmd.insert) begin
			next_count = count_q + CNT_W'(1);
		end else if (cmd.remove) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	// The reported count is the count after the operation, masked to four bits.
	assign cnt_ext = {4'b0000, next_count};

	// Build the result from the cells as they stand before the update: the head
	// after the operation is the new job, the second cell, or the current head.
	always_comb begin
		res                  = '0;
		res.job_count        = cnt_ext[3:0];
		if (req.operation == OP_REMOVE) begin
			if (empty) begin
				res.status = ST_EMPTY;
			end else begin
				res.status           = ST_DONE;
				res.removed_id       = job_q[0].id;
				res.removed_priority = job_q[0].prio;
				if (count_q > CNT_W'(1)) begin
					res.head_id       = job_q[1].id;
					res.head_priority = job_q[1].prio;
				end
			end
		end else begin
			if (full) begin
				res.status        = ST_FULL;
				res.head_id       = job_q[0].id;
				res.head_priority = job_q[0].prio;
			end else begin
				res.status = ST_DONE;
				if (stay[0]) begin
					res.head_id       = job_q[0].id;
					res.head_priority = job_q[0].prio;
				end else begin
					res.head_id       = req.job_id;
					res.head_priority = req.job_priority;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= next_count;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = res_q.status;
	assign rsp.removed_id       = res_q.removed_id;
	assign rsp.removed_priority = res_q.removed_priority;
	assign rsp.job_count        = res_q.job_count;
	assign rsp.head_id          = res_q.head_id;
	assign rsp.head_priority    = res_q.head_priority;

	// Occupied neighbors must never be out of priority order.
	always_comb begin
		sorted_ok = 1'b1;
		for (int k = 1; k < QUEUE_DEPTH; k++) begin
			if (occ[k] && (job_q[k].prio < job_q[k-1].prio)) begin
				sorted_ok = 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("job count exceeds queue depth");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n) sorted_ok)
		else $error("held jobs are out of priority order");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not raise the job count");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_EMPTY) |->
		(rsp.job_count == 4'd0 && rsp.head_id == 16'd0 && rsp.removed_id == 16'd0))
		else $error("empty remove reported a job");

endmodule
`default_nettype wire

// File: sim/tb_sorted_priority_job_queue.sv
// Self-checking testbench for the sorted priority job queue, with its own queue predictor.
`default_nettype none
module tb_sorted_priority_job_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spjq_pkg::*;

	// The run stays far below this limit even with heavy idling on both sides,
	// so the limit only catches a hung handshake.
	localparam int CYCLE_LIMIT = 200000;
	// The result is registered, so a short drain is enough to catch stray beats.
	localparam int DRAIN_CYCLES = 10;
	// Keeps a broken design from flooding the log.
	localparam int REPORT_CAP = 40;
	localparam int RANDOM_PER_PHASE = 258;

	logic clk = 1'b0;
	logic arst_n;

	spjq_req_if req ();
	spjq_rsp_if rsp ();

	sorted_priority_job_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// 12 ns period: low half, then high half.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Jobs the queue should hold right now, head first. This is the
	// predictor's own copy of the block's state.
	job_t    held_jobs[$];
	// Results still owed by the block, oldest first.
	result_t pending_results[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	// Chance, in percent, that the sender idles before a beat and that the
	// receiver holds off ready in a given cycle.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Applies one accepted request to the predicted queue and returns the
	// result it must produce. An insert goes behind every job whose priority
	// is not larger, so equal priorities leave in arrival order.
	function automatic result_t predict_queue_op(logic op, logic [15:0] id, logic [7:0] prio);
		result_t r;
		job_t    j;
		int      pos;
		r = '0;
		r.status = ST_DONE;
		if (op == OP_REMOVE) begin
			if (held_jobs.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				j = held_jobs.pop_front();
				r.removed_id = j.id;
				r.removed_priority = j.prio;
			end
		end else if (held_jobs.size() >= QUEUE_DEPTH) begin
			// A full queue refuses the job and stays as it was.
			r.status = ST_FULL;
		end else begin
			pos = 0;
			while (pos < held_jobs.size() && held_jobs[pos].prio <= prio)
				pos++;
			j.id = id;
			j.prio = prio;
			held_jobs.insert(pos, j);
		end
		// The count field is four bits wide and wraps for deep queues.
		r.job_count = 4'(held_jobs.size());
		if (held_jobs.size() != 0) begin
			r.head_id = held_jobs[0].id;
			r.head_priority = held_jobs[0].prio;
		end
		return r;
	endfunction

	// Offers one request beat, idling first at the current sender rate, and
	// records the expected result at the edge where the beat is taken. Every
	// call starts on a falling edge, so valid is never lowered and raised in
	// the same time step.
	task automatic send_job(input logic op, input logic [15:0] id, input logic [7:0] prio);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			req.operation <= 1'($urandom);
			req.job_id <= 16'($urandom);
			req.job_priority <= 8'($urandom);
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.job_id <= id;
		req.job_priority <= prio;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		pending_results.push_back(predict_queue_op(op, id, prio));
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$realtime, field, want, got);
		end
	endtask

	// Receiver: ready is redrawn on every falling edge at the current stall rate.
	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Result checker: every taken result beat is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_beat
		result_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: result beat with nothing expected, expected none, actual status 0x%0h count 0x%0h",
						$realtime, rsp.status, rsp.job_count);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 16'(want.status), 16'(rsp.status));
				check_field("removed_id", want.removed_id, rsp.removed_id);
				check_field("removed_priority", 16'(want.removed_priority),
					16'(rsp.removed_priority));
				check_field("job_count", 16'(want.job_count), 16'(rsp.job_count));
				check_field("head_id", want.head_id, rsp.head_id);
				check_field("head_priority", 16'(want.head_priority), 16'(rsp.head_priority));
			end
		end
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Removing from an empty queue must report empty with all other fields zero.
	task automatic test_remove_empty();
		send_job(OP_REMOVE, 16'hffff, 8'hff);
	endtask

	// Fills the queue with extreme ids and priorities plus a run of equal
	// priorities, then pushes one job into the full queue, which must be refused.
	task automatic test_fill_to_full();
		send_job(OP_INSERT, 16'hffff, 8'hff);
		send_job(OP_INSERT, 16'h0000, 8'h00);
		send_job(OP_INSERT, 16'h0001, 8'h80);
		send_job(OP_INSERT, 16'h0002, 8'h80);
		send_job(OP_INSERT, 16'h0003, 8'h80);
		send_job(OP_INSERT, 16'h5555, 8'h7f);
		send_job(OP_INSERT, 16'haaaa, 8'h80);
		send_job(OP_INSERT, 16'h1234, 8'hff);
		send_job(OP_INSERT, 16'hbeef, 8'h00);
	endtask

	// Drains everything: equal priorities must leave in arrival order, and the
	// final remove hits the empty queue again.
	task automatic test_drain_in_order();
		for (int k = 0; k <= QUEUE_DEPTH; k++)
			send_job(OP_REMOVE, 16'($urandom), 8'($urandom));
	endtask

	// Random traffic. The insert share changes in bursts, so the queue keeps
	// swinging between empty and full. Priorities often come from a tiny set to
	// force ties, sometimes sit at the extremes, and otherwise span the range.
	task automatic test_random_traffic(input int unsigned beats, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned insert_pct;
		int unsigned burst_left;
		int unsigned pick;
		logic        op;
		logic [7:0]  prio;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		burst_left = 0;
		insert_pct = 50;
		for (int unsigned n = 0; n < beats; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 12);
				case ($urandom_range(2))
					0: begin
						insert_pct = 25;
					end
					1: begin
						insert_pct = 50;
					end
					default: begin
						insert_pct = 75;
					end
				endcase
			end
			burst_left--;
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			pick = $urandom_range(9);
			if (pick < 5)
				prio = 8'($urandom_range(3));
			else if (pick == 5)
				prio = 8'h00;
			else if (pick == 6)
				prio = 8'hff;
			else
				prio = 8'($urandom);
			send_job(op, 16'($urandom), prio);
		end
	endtask

	initial begin
		// Every input is known from time zero; reset is held, then released on a falling edge.
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_INSERT;
		req.job_id = '0;
		req.job_priority = '0;
		rsp.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_remove_empty();
		test_fill_to_full();
		test_drain_in_order();

		// No idling, then a slow sender, then a slow receiver, then both.
		test_random_traffic(RANDOM_PER_PHASE, 0, 0);
		test_random_traffic(RANDOM_PER_PHASE, 80, 0);
		test_random_traffic(RANDOM_PER_PHASE, 0, 80);
		test_random_traffic(RANDOM_PER_PHASE, 21, 21);

		@(negedge clk);
		req.valid <= 1'b0;
		// Let the receiver take everything that is still owed.
		recv_stall_pct = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hdl/spjq_pkg.sv
hdl/spjq_if.sv
hdl/spjq_cell.sv
hdl/sorted_priority_job_queue.sv
sim/tb_sorted_priority_job_queue.sv
